// File: hdl/cvde_pkg.sv
`default_nettype none
package cvde_pkg;
  localparam int MaxWidth = 1024;
  localparam int ColW = $clog2(MaxWidth);
  localparam int LsAddrW = $clog2(2 * MaxWidth);
  localparam int PixW = 24;
  localparam int DistW = 13;
  localparam int SumW = 16;
  localparam int ProdW = 20;

  typedef enum logic [1:0] {
    REG_HIGH_RANK = 2'd0,
    REG_LOW_RANK  = 2'd1,
    REG_WIDTH     = 2'd2,
    REG_HEIGHT    = 2'd3
  } reg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD, ST_LOAD, ST_DIST, ST_SORT, ST_SUML, ST_MIN, ST_DIV, ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } sqrt_ctl_t;
endpackage
`default_nettype wire

// File: hdl/cvde_if.sv
`default_nettype none
interface pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

interface edge_if;
  logic       valid;
  logic       ready;
  logic [7:0] edge_value;
  logic       last_of_frame;
  modport source (output valid, edge_value, last_of_frame, input ready);
  modport sink (input valid, edge_value, last_of_frame, output ready);
endinterface

interface cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: hdl/cvde_ram.sv
`default_nettype none
module cvde_ram #(
  parameter int Width = 24,
  parameter int Depth = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output      logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: hdl/cvde_sqrt.sv
`default_nettype none
module cvde_sqrt (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [25:0]        radicand,
  output      logic               done,
  output      logic [cvde_pkg::DistW-1:0] root
);
  import cvde_pkg::*;
  logic [25:0] rem;
  logic [25:0] res;
  logic [25:0] bitv;
  logic        busy;
  logic [25:0] trial;
  logic [13:0] s;
  assign trial = res + bitv;
  assign s = res[13:0];
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem  <= radicand;
        res  <= '0;
        bitv <= 26'd1 << 24;
      end else if (busy) begin
        if (bitv == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
          root <= (rem > {12'd0, s}) ? DistW'(s + 14'd1) : DistW'(s);
        end else begin
          if (rem >= trial) begin
            rem <= rem - trial;
            res <= (res >> 1) + bitv;
          end else begin
            res <= res >> 1;
          end
          bitv <= bitv >> 2;
        end
      end
    end
  end
endmodule
`default_nettype wire

// File: hdl/color_vector_dispersion_edge.sv
// channel | dir | payload
// pix     | in  | red, green, blue
// edges   | out | edge_value, last_of_frame
// cfg     | in  | index, data
// A border item goes through accept, line-store read and window load, and gives no result.
// An interior item, after accept, goes through the line-store read and window load,
// distances for 36 pixel pairs through one shared square-root unit, 9 sort passes,
// l sum and k compare steps, a restoring divide and the output register.
// Synchronous reset clears control and the window. The output register holds a
// result while the sink stalls; the block takes no new item until it is taken.
`default_nettype none
module color_vector_dispersion_edge (
  input wire logic clk,
  input wire logic rst,
  pix_if.sink      pix,
  edge_if.source   edges,
  cfg_if.sink      cfg
);
  import cvde_pkg::*;
  state_t state, state_next;
  logic [3:0]  kreg, lreg;
  logic [10:0] wreg;
  logic [15:0] hreg;
  logic [ColW-1:0] col;
  logic [15:0] row;
  logic [PixW-1:0] win [9];
  logic [PixW-1:0] cur;
  logic [SumW-1:0] sums [9];
  logic [3:0] ia, ib, kk, lk, cnt;
  logic [ProdW-1:0] suml, best, num, quo;
  logic [4:0] den;
  logic last;
  logic [10:0] w_eff;
  logic [15:0] h_eff;
  logic [ColW-1:0] x;
  logic [15:0] y;
  logic [PixW-1:0] rd_top, rd_mid;
  logic ram_we;
  logic [LsAddrW-1:0] waddr, raddr;
  logic [PixW-1:0] wdata;
  logic sq_start, sq_done;
  logic [DistW-1:0] pair_dist;
  logic [25:0] rad;
  logic signed [8:0] dr, dg, db;
  logic phase;

  assign w_eff = (wreg < 11'd3) ? 11'd3 : (wreg > 11'(MaxWidth)) ? 11'(MaxWidth) : wreg;
  assign h_eff = (hreg < 16'd3) ? 16'd3 : hreg;
  assign x = (11'(col) >= w_eff) ? '0 : col;
  assign y = ((11'(col) >= w_eff ? row + 16'd1 : row) >= h_eff) ? 16'd0 :
             (11'(col) >= w_eff ? row + 16'd1 : row);

  cvde_ram #(.Width(PixW), .Depth(2 * MaxWidth)) u_ls (
    .clk, .we(ram_we), .waddr, .wdata, .raddr, .rdata(rd_top)
  );
  assign rd_mid = rd_top;

  always_comb begin
    dr = 9'(win[ia][7:0]) - 9'(win[ib][7:0]);
    dg = 9'(win[ia][15:8]) - 9'(win[ib][15:8]);
    db = 9'(win[ia][23:16]) - 9'(win[ib][23:16]);
    rad = {(18'(dr * dr) + 18'(dg * dg) + 18'(db * db)), 8'd0};
  end
  cvde_sqrt u_sqrt (
    .clk, .rst, .start(sq_start), .radicand(rad), .done(sq_done), .root(pair_dist)
  );

  assign pix.ready = (state == ST_IDLE) && !edges.valid;
  assign cfg.ready = 1'b1;

  always_comb begin
    state_next = state;
    sq_start = 1'b0;
    unique case (state)
      ST_IDLE: if (pix.valid && pix.ready) state_next = ST_RD;
      ST_RD:   state_next = ST_LOAD;
      ST_LOAD: state_next = (x >= 10'd2 && y >= 16'd2) ? ST_DIST : ST_IDLE;
      ST_DIST: begin
        sq_start = !phase;
        if (sq_done && ia == 4'd7 && ib == 4'd8) state_next = ST_SORT;
      end
      ST_SORT: if (cnt == 4'd8 && ia == 4'd7) state_next = ST_SUML;
      ST_SUML: if (ia == lk - 4'd1) state_next = ST_MIN;
      ST_MIN:  if (ia == kk - 4'd1) state_next = ST_DIV;
      ST_DIV:  if (ia == 4'd8) state_next = ST_OUT;
      ST_OUT:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    ram_we = 1'b0;
    waddr = '0;
    wdata = cur;
    raddr = {1'b1, x};
    if (state == ST_RD) begin
      raddr = {1'b0, x};
      ram_we = 1'b1;
      waddr = {1'b0, x};
      wdata = cur;
    end
    if (state == ST_LOAD) begin
      ram_we = 1'b1;
      waddr = {1'b1, x};
      wdata = rd_mid;
    end
  end

  logic [PixW-1:0] top_q;
  logic [ProdW-1:0] big, diff;
  assign big = ProdW'(sums[4'd8 - ia]) * ProdW'(lk);
  assign diff = (big >= suml) ? big - suml : suml - big;

  always_ff @(posedge clk) begin
    if (rst) begin
      kreg <= 4'd1; lreg <= 4'd1; wreg <= 11'd1024; hreg <= 16'd1024;
      col <= '0; row <= '0;
      edges.valid <= 1'b0;
      phase <= 1'b0;
      for (int i = 0; i < 9; i++) win[i] <= '0;
    end else begin
      if (cfg.valid) begin
        unique case (reg_index_t'(cfg.index))
          REG_HIGH_RANK: kreg <= cfg.data[3:0];
          REG_LOW_RANK:  lreg <= cfg.data[3:0];
          REG_WIDTH:     wreg <= cfg.data[10:0];
          REG_HEIGHT:    hreg <= cfg.data[15:0];
          default: ;
        endcase
      end
      if (edges.valid && edges.ready) edges.valid <= 1'b0;
      unique case (state)
        ST_IDLE: if (pix.valid && pix.ready) begin
          cur <= {pix.blue, pix.green, pix.red};
          kk <= (kreg == 4'd0) ? 4'd1 : (kreg > 4'd9) ? 4'd9 : kreg;
          lk <= (lreg == 4'd0) ? 4'd1 : (lreg > 4'd9) ? 4'd9 : lreg;
        end
        ST_RD: top_q <= rd_top;
        ST_LOAD: begin
          win[0] <= win[1]; win[1] <= win[2]; win[2] <= top_q;
          win[3] <= win[4]; win[4] <= win[5]; win[5] <= rd_mid;
          win[6] <= win[7]; win[7] <= win[8]; win[8] <= cur;
          last <= (11'(x) == w_eff - 11'd1) && (y == h_eff - 16'd1);
          if (11'(x) + 11'd1 >= w_eff) begin
            col <= '0;
            row <= (y + 16'd1 >= h_eff) ? 16'd0 : y + 16'd1;
          end else begin
            col <= x + 1'b1;
            row <= y;
          end
          for (int i = 0; i < 9; i++) sums[i] <= '0;
          ia <= 4'd0; ib <= 4'd1; phase <= 1'b0;
        end
        ST_DIST: begin
          if (!phase) phase <= 1'b1;
          if (sq_done) begin
            sums[ia] <= sums[ia] + SumW'(pair_dist);
            sums[ib] <= sums[ib] + SumW'(pair_dist);
            phase <= 1'b0;
            if (ia == 4'd7 && ib == 4'd8) begin
              ia <= 4'd0; cnt <= 4'd0;
            end else if (ib == 4'd8) begin
              ia <= ia + 4'd1; ib <= ia + 4'd2;
            end else ib <= ib + 4'd1;
          end
        end
        ST_SORT: begin
          if (sums[ia] > sums[ia + 4'd1]) begin
            sums[ia] <= sums[ia + 4'd1];
            sums[ia + 4'd1] <= sums[ia];
          end
          if (ia == 4'd7) begin
            ia <= 4'd0; cnt <= cnt + 4'd1;
            if (cnt == 4'd8) suml <= '0;
          end else ia <= ia + 4'd1;
        end
        ST_SUML: begin
          suml <= suml + ProdW'(sums[ia]);
          if (ia == lk - 4'd1) begin
            ia <= 4'd0; best <= '1;
          end else ia <= ia + 4'd1;
        end
        ST_MIN: begin
          if (diff < best) best <= diff;
          if (ia == kk - 4'd1) begin
            num <= ((diff < best) ? diff : best) + ProdW'({lk, 3'd0});
            den <= {1'b0, lk};
            quo <= '0;
            cnt <= 4'd0;
            ia <= 4'd0;
          end else ia <= ia + 4'd1;
        end
        ST_DIV: begin
          // restoring divide by 16*l, one quotient bit per cycle from bit 8
          if (num >= (ProdW'(den) << (4 + 8 - ia))) begin
            num <= num - (ProdW'(den) << (4 + 8 - ia));
            quo <= quo | (ProdW'(1) << (8 - ia));
          end
          if (ia == 4'd8) cnt <= 4'd0;
          else begin
            ia <= ia + 4'd1; cnt <= 4'd1;
          end
        end
        ST_OUT: begin
          edges.valid <= 1'b1;
          edges.edge_value <= (quo > ProdW'(255)) ? 8'd255 : quo[7:0];
          edges.last_of_frame <= last;
        end
        default: ;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !pix.ready) else $error("ready while busy");
  a_out_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(edges.valid) |-> $past(state) == ST_OUT) else $error("stray result");
  a_one_out: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT) |-> !edges.valid) else $error("result overwritten");
`endif
endmodule
`default_nettype wire
